FILE: design/pidaw_pkg.sv
// Shared types and constants for the PID regulator with output clamp and anti-windup.
package pidaw_pkg;

  // Item modes
  localparam logic [1:0] MODE_UPDATE  = 2'd0;
  localparam logic [1:0] MODE_PREVIEW = 2'd1;
  localparam logic [1:0] MODE_LOAD    = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN_P       = 3'd0;
  localparam logic [2:0] REG_GAIN_I       = 3'd1;
  localparam logic [2:0] REG_GAIN_D       = 3'd2;
  localparam logic [2:0] REG_STEP_TIME    = 3'd3;
  localparam logic [2:0] REG_CLAMP_MAG    = 3'd4;
  localparam logic [2:0] REG_WINDUP_GUARD = 3'd5;

  // Derivative divide: 33-bit error difference magnitude scaled by 2^16
  localparam int DIVIDEND_W = 49;
  localparam int DIVISOR_W  = 31;
  localparam int DIV_CNT_W  = 6;

  // Status of the iterative divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/pidaw_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
module pidaw_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [pidaw_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [pidaw_pkg::DIVISOR_W-1:0]      divisor,
  output logic [pidaw_pkg::DIVIDEND_W-1:0]     quotient,
  output pidaw_pkg::div_stat_t                 stat
);

  logic [pidaw_pkg::DIV_CNT_W-1:0]   cnt;
  logic [pidaw_pkg::DIVISOR_W-1:0]   rem;
  logic [pidaw_pkg::DIVISOR_W:0]     rem_sh;
  logic [pidaw_pkg::DIVISOR_W:0]     rem_sub;
  logic                              fits;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    rem_sh  = {rem, quotient[pidaw_pkg::DIVIDEND_W-1]};
    fits    = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // Quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      quotient  <= dividend;
      rem       <= '0;
      cnt       <= pidaw_pkg::DIV_CNT_W'(pidaw_pkg::DIVIDEND_W - 1);
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
    end else if (stat.busy) begin
      quotient <= {quotient[pidaw_pkg::DIVIDEND_W-2:0], fits};
      rem      <= fits ? rem_sub[pidaw_pkg::DIVISOR_W-1:0] : rem_sh[pidaw_pkg::DIVISOR_W-1:0];
      cnt      <= cnt - 1'b1;
      if (cnt == '0) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

endmodule

FILE: design/pid_controller_antiwindup.sv
// Top level of the per-channel PID regulator with output clamp and anti-windup.
//
//  Channel   Signals                                            Driven by
//  --------  -------------------------------------------------  ---------
//  item      item_valid, item_stall, mode, channel, target,     source
//            measured, load_integral, load_prev_error
//  result    result_valid, result_stall, control                block
//  config    cfg_write, cfg_index, cfg_data                     host
//
// An update or preview beat steps through the sequencer states from S_ERR to S_CLAMP,
// waiting in S_DIV_WAIT for the derivative divider unless the control period is zero.
// A load beat, or a beat that is ignored, goes from S_IDLE straight to S_DONE.
// Reset clears the gains to their defaults and every channel's state to zero.
// item_stall is high while a beat is at work; a finished result waits in the
// output register while result_stall is high and a new beat may be taken.
module pid_controller_antiwindup #(
  parameter int CHANNELS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         mode,
  input  logic [1:0]         channel,
  input  logic signed [31:0] target,
  input  logic signed [31:0] measured,
  input  logic signed [31:0] load_integral,
  input  logic signed [31:0] load_prev_error,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] control,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_MUL_INT, S_INTEG, S_MUL_P, S_ACC_P, S_MUL_I, S_ACC_I,
    S_DIV_WAIT, S_MUL_D, S_ACC_D, S_CLAMP, S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic [30:0]        step_time;
  logic [30:0]        clamp_mag;
  logic               windup_guard;

  // Per-channel state
  logic signed [31:0] integral_sum [CHANNELS];
  logic signed [31:0] last_error   [CHANNELS];

  // Working registers
  logic [1:0]         mode_r;
  logic [IdxW-1:0]    idx_r;
  logic signed [31:0] target_r;
  logic signed [31:0] measured_r;
  logic signed [31:0] err;
  logic signed [31:0] last_r;
  logic signed [31:0] integ;
  logic signed [31:0] deriv;
  logic signed [63:0] prod;
  logic signed [49:0] acc;
  logic signed [31:0] res;
  logic signed [31:0] drive;

  // Combinational helpers
  logic                 accept;
  logic [IdxW+1:0]      chan_wide;
  logic [IdxW-1:0]      item_idx;
  logic                 chan_ok;
  logic signed [32:0]   err_diff;
  logic signed [31:0]   err_sat;
  logic signed [32:0]   d_diff;
  logic [32:0]          d_mag;
  logic                 d_neg;
  logic [pidaw_pkg::DIVIDEND_W-1:0] div_q;
  pidaw_pkg::div_stat_t div_stat;
  logic                 div_start;
  logic signed [31:0]   deriv_sat;
  logic signed [31:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic signed [63:0]   mul_p;
  logic signed [47:0]   prod_q;
  logic signed [48:0]   integ_sum;
  logic signed [31:0]   integ_sat;
  logic signed [49:0]   lim_pos;
  logic signed [49:0]   lim_neg;
  logic                 clamped;
  logic signed [31:0]   clamp_res;
  logic                 result_free;

  assign accept      = item_valid && !item_stall;
  assign item_stall  = (state != S_IDLE);
  assign control     = drive;
  assign result_free = !result_valid || !result_stall;

  // Channel decode
  always_comb begin
    chan_wide = (IdxW + 2)'(channel);
    item_idx  = chan_wide[IdxW-1:0];
    chan_ok   = (int'(channel) < CHANNELS);
  end

  // Error, saturated to 32 bits
  always_comb begin
    err_diff = {target_r[31], target_r} - {measured_r[31], measured_r};
    if (err_diff[32] != err_diff[31]) begin
      err_sat = err_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err_sat = err_diff[31:0];
    end
  end

  // Derivative dividend: magnitude of the error difference scaled by 2^16
  always_comb begin
    d_diff = {err[31], err} - {last_r[31], last_r};
    d_neg  = d_diff[32];
    d_mag  = d_neg ? 33'(-d_diff) : 33'(d_diff);
  end

  assign div_start = (state == S_MUL_INT) && (step_time != '0);

  pidaw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({d_mag, 16'h0000}),
    .divisor  (step_time),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Signed quotient, saturated to 32 bits
  always_comb begin
    if (d_neg) begin
      if (div_q > pidaw_pkg::DIVIDEND_W'(64'h8000_0000)) begin
        deriv_sat = 32'sh8000_0000;
      end else begin
        deriv_sat = 32'(-div_q[31:0]);
      end
    end else begin
      if (div_q > pidaw_pkg::DIVIDEND_W'(64'h7fff_ffff)) begin
        deriv_sat = 32'sh7fff_ffff;
      end else begin
        deriv_sat = div_q[31:0];
      end
    end
  end

  // Shared multiplier operand selection
  always_comb begin
    case (state)
      S_MUL_INT: begin
        mul_a = err;
        mul_b = {1'b0, step_time};
      end
      S_MUL_P: begin
        mul_a = gain_p;
        mul_b = err;
      end
      S_MUL_I: begin
        mul_a = gain_i;
        mul_b = integ;
      end
      S_MUL_D: begin
        mul_a = gain_d;
        mul_b = deriv;
      end
      default: begin
        mul_a = err;
        mul_b = err;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Product floor-shifted back to Q16.16, and the saturating integral step
  always_comb begin
    prod_q    = prod[63:16];
    integ_sum = {{17{integ[31]}}, integ} + 49'(prod_q);
    if (integ_sum > 49'sh0_7fff_ffff) begin
      integ_sat = 32'sh7fff_ffff;
    end else if (integ_sum < -49'sh0_8000_0000) begin
      integ_sat = 32'sh8000_0000;
    end else begin
      integ_sat = integ_sum[31:0];
    end
  end

  // Output clamp, then saturation to 32 bits
  always_comb begin
    lim_pos = {19'b0, clamp_mag};
    lim_neg = -lim_pos;
    clamped = 1'b0;
    if (clamp_mag != '0 && acc > lim_pos) begin
      clamped   = 1'b1;
      clamp_res = lim_pos[31:0];
    end else if (clamp_mag != '0 && acc < lim_neg) begin
      clamped   = 1'b1;
      clamp_res = lim_neg[31:0];
    end else if (acc > 50'sh0_7fff_ffff) begin
      clamp_res = 32'sh7fff_ffff;
    end else if (acc < -50'sh0_8000_0000) begin
      clamp_res = 32'sh8000_0000;
    end else begin
      clamp_res = acc[31:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= 32'sd65536;
      gain_i       <= '0;
      gain_d       <= '0;
      step_time    <= 31'd655;
      clamp_mag    <= '0;
      windup_guard <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        pidaw_pkg::REG_GAIN_P:       gain_p       <= cfg_data;
        pidaw_pkg::REG_GAIN_I:       gain_i       <= cfg_data;
        pidaw_pkg::REG_GAIN_D:       gain_d       <= cfg_data;
        pidaw_pkg::REG_STEP_TIME:    step_time    <= cfg_data[30:0];
        pidaw_pkg::REG_CLAMP_MAG:    clamp_mag    <= cfg_data[30:0];
        pidaw_pkg::REG_WINDUP_GUARD: windup_guard <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer, channel state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        integral_sum[i] <= '0;
        last_error[i]   <= '0;
      end
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_r     <= mode;
            idx_r      <= item_idx;
            target_r   <= target;
            measured_r <= measured;
            res        <= '0;
            if (chan_ok && (mode == pidaw_pkg::MODE_UPDATE ||
                            mode == pidaw_pkg::MODE_PREVIEW)) begin
              state <= S_ERR;
            end else begin
              if (chan_ok && mode == pidaw_pkg::MODE_LOAD) begin
                integral_sum[item_idx] <= load_integral;
                last_error[item_idx]   <= load_prev_error;
              end
              state <= S_DONE;
            end
          end
        end
        S_ERR: begin
          err    <= err_sat;
          integ  <= integral_sum[idx_r];
          last_r <= last_error[idx_r];
          state  <= S_MUL_INT;
        end
        S_MUL_INT: begin
          prod  <= mul_p;
          state <= S_INTEG;
        end
        S_INTEG: begin
          if (step_time != '0) begin
            integ <= integ_sat;
          end
          state <= S_MUL_P;
        end
        S_MUL_P: begin
          prod  <= mul_p;
          state <= S_ACC_P;
        end
        S_ACC_P: begin
          acc   <= 50'(prod_q);
          state <= S_MUL_I;
        end
        S_MUL_I: begin
          prod  <= mul_p;
          state <= S_ACC_I;
        end
        S_ACC_I: begin
          acc   <= acc + 50'(prod_q);
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (step_time == '0) begin
            deriv <= '0;
            state <= S_MUL_D;
          end else if (div_stat.done) begin
            deriv <= deriv_sat;
            state <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          prod  <= mul_p;
          state <= S_ACC_D;
        end
        S_ACC_D: begin
          acc   <= acc + 50'(prod_q);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          res <= clamp_res;
          if (mode_r == pidaw_pkg::MODE_UPDATE) begin
            last_error[idx_r] <= err;
            if (!(windup_guard && clamped)) begin
              integral_sum[idx_r] <= integ;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // The output register only takes a new beat once the old one has left.
          if (result_free) begin
            drive        <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divider only runs while a beat is being worked on.
  a_div_busy_in_item: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state != S_IDLE && state != S_DONE))
    else $error("divider running outside an item");

  // A clamped result never exceeds the output limit.
  a_clamp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLAMP && clamp_mag != '0) |=>
      ($signed({res[31], res}) <= $signed({2'b00, clamp_mag}) &&
       $signed({res[31], res}) >= -$signed({2'b00, clamp_mag})))
    else $error("result outside the output limit");

  // A preview leaves the channel integral and last error untouched.
  a_preview_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLAMP && mode_r == pidaw_pkg::MODE_PREVIEW) |=>
      (integral_sum[idx_r] == $past(integral_sum[idx_r]) &&
       last_error[idx_r] == $past(last_error[idx_r])))
    else $error("preview changed channel state");

  // The result register is only loaded from the final state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");

endmodule
